>>> rtl/core/pvs_pkg.sv
// Shared constants, types and command/status structs of the polygon vertex simplifier.
package pvs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 20;
  localparam int THR_WIDTH    = 19;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_WIDTH + 1;
  localparam int MAG_W        = (DIFF_W > THR_WIDTH) ? DIFF_W : THR_WIDTH;
  localparam int MUL_W        = 2 * MAG_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 2 * MAG_W + 2;
  localparam int MCNT_W       = $clog2(MUL_W + 1);
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LINE  = CFG_IDX_W'(1);
  localparam logic [THR_WIDTH-1:0] THR_RESET = THR_WIDTH'(16);

  // Multiplier operand sources.
  typedef enum logic [3:0] {
    SRC_APX, SRC_APY, SRC_ABX, SRC_ABY, SRC_DX, SRC_DY,
    SRC_LINE, SRC_CROSS, SRC_L2, SRC_AB2
  } src_t;

  // Where a finished product goes.
  typedef enum logic [2:0] {
    DST_ACC_LOAD, DST_ACC_ADD, DST_ACC_SUB, DST_SQ,
    DST_SUM_LOAD, DST_SUM_ADD, DST_AUX
  } dst_t;

  // Source of the successor vertex register.
  typedef enum logic [1:0] {NX_HOLD, NX_MEM, NX_FIRST, NX_CUR} nxsel_t;

  typedef enum logic [3:0] {
    S_LOAD, S_INIT0, S_INIT1, S_INIT2, S_FETCH, S_FLAT, S_TEST,
    S_MISSUE, S_MWAIT, S_NEXT, S_APPLY, S_ESCAN, S_ELAT, S_EOUT
  } state_t;

  // Multiply steps of the segment distance test.
  typedef enum logic [3:0] {
    ST_D1A, ST_D1B, ST_EAP1, ST_EAP2, ST_LL, ST_D2A, ST_D2B, ST_ED1,
    ST_ED2, ST_C1, ST_C2, ST_CSQ, ST_AB1, ST_AB2, ST_CL, ST_CR
  } step_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             ld_prev_rd;
    logic             ld_cur_rd;
    nxsel_t           nx_sel;
    logic             adv;
    logic             keep;
    logic             set_first;
    logic             mul_start;
    src_t             src_a;
    src_t             src_b;
    dst_t             dst;
    logic             out_ld;
    logic             out_empty;
    logic             out_last;
    logic             out_ovf;
  } cmd_t;

  typedef struct packed {
    logic point_close;
    logic acc_neg;
    logic acc_pos;
    logic ab_zero;
    logic sum_lt_aux;
    logic sq_lt_aux;
    logic mul_done;
  } status_t;

endpackage

>>> rtl/core/pvs_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module pvs_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pvs_pkg::MUL_W-1:0]  a,
  input  logic [pvs_pkg::MUL_W-1:0]  b,
  output logic                       done,
  output logic [pvs_pkg::PROD_W-1:0] prod
);
  import pvs_pkg::*;

  logic [MUL_W-1:0]  a_r;
  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;
  logic [MCNT_W-1:0] cnt_r;
  logic              done_r;
  logic [MUL_W:0]    sum;

  // Add the multiplicand into the upper half when the low bit is set, then shift right.
  always_comb begin
    sum   = {1'b0, p_r[PROD_W-1:MUL_W]} + {1'b0, (p_r[0] ? a_r : MUL_W'(0))};
    p_nxt = {sum, p_r[MUL_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r   <= a;
        p_r   <= {MUL_W'(0), b};
        cnt_r <= MCNT_W'(MUL_W);
      end else if (cnt_r != '0) begin
        p_r   <= p_nxt;
        cnt_r <= cnt_r - MCNT_W'(1);
        if (cnt_r == MCNT_W'(1)) done_r <= 1'b1;
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;
endmodule

>>> rtl/core/pvs_datapath.sv
// Vertex store, neighbour registers, exact squared distance arithmetic and output register.
module pvs_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pvs_pkg::THR_WIDTH-1:0]     cfg_wdata,
  input  logic signed [pvs_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [pvs_pkg::COORD_WIDTH-1:0] in_y,
  input  pvs_pkg::cmd_t                     cmd,
  output pvs_pkg::status_t                  status,
  output logic signed [pvs_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [pvs_pkg::COORD_WIDTH-1:0] out_y,
  output logic                              out_last,
  output logic                              out_empty,
  output logic                              out_ovf
);
  import pvs_pkg::*;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x_r, rd_y_r;
  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, cur_x_r, cur_y_r;
  logic signed [COORD_WIDTH-1:0] nx_x_r, nx_y_r, first_x_r, first_y_r;
  logic signed [COORD_WIDTH-1:0] out_x_r, out_y_r;
  logic                          out_last_r, out_empty_r, out_ovf_r;
  logic [THR_WIDTH-1:0]          pt_r, ln_r;
  logic signed [ACC_W-1:0]       acc_r;
  logic [PROD_W-1:0]             sq_r, sum_r, aux_r;
  logic                          sgn_r;
  dst_t                          dst_r;

  logic signed [DIFF_W-1:0] dx, dy, apx, apy, abx, aby;
  logic [MUL_W-1:0]         m_dx, m_dy, m_apx, m_apy, m_abx, m_aby, m_cross;
  logic [MUL_W-1:0]         mag_a, mag_b;
  logic                     neg_a, neg_b;
  logic                     mul_done;
  logic [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]  sprod;

  function automatic logic [MUL_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? DIFF_W'(-v) : v;
    return MUL_W'(m);
  endfunction

  // Coordinate differences around the current vertex.
  always_comb begin
    dx  = DIFF_W'(cur_x_r) - DIFF_W'(nx_x_r);
    dy  = DIFF_W'(cur_y_r) - DIFF_W'(nx_y_r);
    apx = DIFF_W'(cur_x_r) - DIFF_W'(prev_x_r);
    apy = DIFF_W'(cur_y_r) - DIFF_W'(prev_y_r);
    abx = DIFF_W'(nx_x_r)  - DIFF_W'(prev_x_r);
    aby = DIFF_W'(nx_y_r)  - DIFF_W'(prev_y_r);
    m_dx  = mag_of(dx);
    m_dy  = mag_of(dy);
    m_apx = mag_of(apx);
    m_apy = mag_of(apy);
    m_abx = mag_of(abx);
    m_aby = mag_of(aby);
    m_cross = acc_r[ACC_W-1] ? MUL_W'(ACC_W'(-acc_r)) : MUL_W'(acc_r);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cmd.src_a)
      SRC_APX:   begin mag_a = m_apx; neg_a = apx[DIFF_W-1]; end
      SRC_APY:   begin mag_a = m_apy; neg_a = apy[DIFF_W-1]; end
      SRC_ABX:   begin mag_a = m_abx; neg_a = abx[DIFF_W-1]; end
      SRC_ABY:   begin mag_a = m_aby; neg_a = aby[DIFF_W-1]; end
      SRC_DX:    begin mag_a = m_dx;  neg_a = dx[DIFF_W-1];  end
      SRC_DY:    begin mag_a = m_dy;  neg_a = dy[DIFF_W-1];  end
      SRC_LINE:  begin mag_a = MUL_W'(ln_r); neg_a = 1'b0; end
      SRC_CROSS: begin mag_a = m_cross; neg_a = 1'b0; end
      SRC_L2:    begin mag_a = aux_r[MUL_W-1:0]; neg_a = 1'b0; end
      SRC_AB2:   begin mag_a = sum_r[MUL_W-1:0]; neg_a = 1'b0; end
      default:   begin mag_a = '0; neg_a = 1'b0; end
    endcase
    case (cmd.src_b)
      SRC_APX:   begin mag_b = m_apx; neg_b = apx[DIFF_W-1]; end
      SRC_APY:   begin mag_b = m_apy; neg_b = apy[DIFF_W-1]; end
      SRC_ABX:   begin mag_b = m_abx; neg_b = abx[DIFF_W-1]; end
      SRC_ABY:   begin mag_b = m_aby; neg_b = aby[DIFF_W-1]; end
      SRC_DX:    begin mag_b = m_dx;  neg_b = dx[DIFF_W-1];  end
      SRC_DY:    begin mag_b = m_dy;  neg_b = dy[DIFF_W-1];  end
      SRC_LINE:  begin mag_b = MUL_W'(ln_r); neg_b = 1'b0; end
      SRC_CROSS: begin mag_b = m_cross; neg_b = 1'b0; end
      SRC_L2:    begin mag_b = aux_r[MUL_W-1:0]; neg_b = 1'b0; end
      SRC_AB2:   begin mag_b = sum_r[MUL_W-1:0]; neg_b = 1'b0; end
      default:   begin mag_b = '0; neg_b = 1'b0; end
    endcase
  end

  pvs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mag_a),
    .b     (mag_b),
    .done  (mul_done),
    .prod  (prod)
  );

  // Signed product; a zero magnitude stays positive.
  assign sprod = sgn_r ? -$signed(prod[ACC_W-1:0]) : $signed(prod[ACC_W-1:0]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pt_r <= THR_RESET;
      ln_r <= THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_POINT) pt_r <= cfg_wdata;
      if (cfg_index == CFG_LINE)  ln_r <= cfg_wdata;
    end
  end

  // Vertex store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_x[cmd.wr_addr] <= in_x;
      mem_y[cmd.wr_addr] <= in_y;
    end
    if (cmd.rd_en) begin
      rd_x_r <= mem_x[cmd.rd_addr];
      rd_y_r <= mem_y[cmd.rd_addr];
    end
  end

  // Neighbour registers: predecessor, current, successor and first kept vertex.
  always_ff @(posedge clk) begin
    if (cmd.ld_prev_rd) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    if (cmd.ld_cur_rd) begin
      cur_x_r <= rd_x_r;
      cur_y_r <= rd_y_r;
    end
    if (cmd.adv) begin
      cur_x_r <= nx_x_r;
      cur_y_r <= nx_y_r;
      if (cmd.keep) begin
        prev_x_r <= cur_x_r;
        prev_y_r <= cur_y_r;
      end
      if (cmd.set_first) begin
        first_x_r <= cur_x_r;
        first_y_r <= cur_y_r;
      end
    end
    case (cmd.nx_sel)
      NX_MEM:   begin nx_x_r <= rd_x_r;    nx_y_r <= rd_y_r;    end
      NX_FIRST: begin nx_x_r <= first_x_r; nx_y_r <= first_y_r; end
      NX_CUR:   begin nx_x_r <= cur_x_r;   nx_y_r <= cur_y_r;   end
      default:  ;
    endcase
  end

  // Product accumulation registers.
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      sgn_r <= neg_a ^ neg_b;
      dst_r <= cmd.dst;
    end
    if (mul_done) begin
      case (dst_r)
        DST_ACC_LOAD: acc_r <= sprod;
        DST_ACC_ADD:  acc_r <= acc_r + sprod;
        DST_ACC_SUB:  acc_r <= acc_r - sprod;
        DST_SQ:       sq_r  <= prod;
        DST_SUM_LOAD: sum_r <= prod;
        DST_SUM_ADD:  sum_r <= sum_r + prod;
        DST_AUX:      aux_r <= prod;
        default:      ;
      endcase
    end
  end

  // Output register, held while the result channel stalls.
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      out_x_r     <= cmd.out_empty ? COORD_WIDTH'(0) : rd_x_r;
      out_y_r     <= cmd.out_empty ? COORD_WIDTH'(0) : rd_y_r;
      out_last_r  <= cmd.out_last;
      out_empty_r <= cmd.out_empty;
      out_ovf_r   <= cmd.out_ovf;
    end
  end

  always_comb begin
    status.point_close = (m_dx < MUL_W'(pt_r)) && (m_dy < MUL_W'(pt_r));
    status.acc_neg     = acc_r[ACC_W-1];
    status.acc_pos     = !acc_r[ACC_W-1] && (acc_r != '0);
    status.ab_zero     = (abx == '0) && (aby == '0);
    status.sum_lt_aux  = sum_r < aux_r;
    status.sq_lt_aux   = sq_r < aux_r;
    status.mul_done    = mul_done;
  end

  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;
  assign out_empty = out_empty_r;
  assign out_ovf   = out_ovf_r;
endmodule

>>> rtl/core/pvs_ctrl.sv
// Controller: vertex loading, ring scan sequencing, multiply steps and result emission.
module pvs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  pvs_pkg::status_t status,
  output pvs_pkg::cmd_t    cmd
);
  import pvs_pkg::*;

  state_t                  state_r, state_nxt;
  step_t                   step_r, step_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [IDX_W-1:0]        nlast_r, nlast_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic [IDX_W-1:0]        lastk_r, lastk_nxt;
  logic [IDX_W-1:0]        e_r, e_nxt;
  logic                    havek_r, havek_nxt;
  logic                    rm_r, rm_nxt;
  logic [MAX_VERTICES-1:0] keep_r, keep_nxt;

  // State and index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      step_r  <= ST_D1A;
      count_r <= '0;
      ovf_r   <= 1'b0;
      nlast_r <= '0;
      cur_r   <= '0;
      lastk_r <= '0;
      e_r     <= '0;
      havek_r <= 1'b0;
      rm_r    <= 1'b0;
      keep_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      nlast_r <= nlast_nxt;
      cur_r   <= cur_nxt;
      lastk_r <= lastk_nxt;
      e_r     <= e_nxt;
      havek_r <= havek_nxt;
      rm_r    <= rm_nxt;
      keep_r  <= keep_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    nlast_nxt = nlast_r;
    cur_nxt   = cur_r;
    lastk_nxt = lastk_r;
    e_nxt     = e_r;
    havek_nxt = havek_r;
    rm_nxt    = rm_r;
    keep_nxt  = keep_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;

    // Operands and destination of the current multiply step.
    case (step_r)
      ST_D1A:  begin cmd.src_a = SRC_APX; cmd.src_b = SRC_ABX; cmd.dst = DST_ACC_LOAD; end
      ST_D1B:  begin cmd.src_a = SRC_APY; cmd.src_b = SRC_ABY; cmd.dst = DST_ACC_ADD;  end
      ST_EAP1: begin cmd.src_a = SRC_APX; cmd.src_b = SRC_APX; cmd.dst = DST_SUM_LOAD; end
      ST_EAP2: begin cmd.src_a = SRC_APY; cmd.src_b = SRC_APY; cmd.dst = DST_SUM_ADD;  end
      ST_D2A:  begin cmd.src_a = SRC_DX;  cmd.src_b = SRC_ABX; cmd.dst = DST_ACC_LOAD; end
      ST_D2B:  begin cmd.src_a = SRC_DY;  cmd.src_b = SRC_ABY; cmd.dst = DST_ACC_ADD;  end
      ST_ED1:  begin cmd.src_a = SRC_DX;  cmd.src_b = SRC_DX;  cmd.dst = DST_SUM_LOAD; end
      ST_ED2:  begin cmd.src_a = SRC_DY;  cmd.src_b = SRC_DY;  cmd.dst = DST_SUM_ADD;  end
      ST_C1:   begin cmd.src_a = SRC_APX; cmd.src_b = SRC_ABY; cmd.dst = DST_ACC_LOAD; end
      ST_C2:   begin cmd.src_a = SRC_APY; cmd.src_b = SRC_ABX; cmd.dst = DST_ACC_SUB;  end
      ST_CSQ:  begin cmd.src_a = SRC_CROSS; cmd.src_b = SRC_CROSS; cmd.dst = DST_SQ;   end
      ST_AB1:  begin cmd.src_a = SRC_ABX; cmd.src_b = SRC_ABX; cmd.dst = DST_SUM_LOAD; end
      ST_AB2:  begin cmd.src_a = SRC_ABY; cmd.src_b = SRC_ABY; cmd.dst = DST_SUM_ADD;  end
      ST_CR:   begin cmd.src_a = SRC_L2;  cmd.src_b = SRC_AB2; cmd.dst = DST_AUX;      end
      default: begin cmd.src_a = SRC_LINE; cmd.src_b = SRC_LINE; cmd.dst = DST_AUX;    end
    endcase

    case (state_r)
      // Store arriving vertices; a vertex beyond capacity only marks overflow.
      S_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_VERTICES)) begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = count_r[IDX_W-1:0];
            count_nxt   = count_r + CNT_W'(1);
            if (in_last) nlast_nxt = count_r[IDX_W-1:0];
          end else begin
            ovf_nxt = 1'b1;
            if (in_last) nlast_nxt = IDX_W'(count_r - CNT_W'(1));
          end
          if (in_last) state_nxt = S_INIT0;
        end
      end
      // The ring's tail is the first predecessor, vertex zero the first current.
      S_INIT0: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = nlast_r;
        state_nxt   = S_INIT1;
      end
      S_INIT1: begin
        cmd.ld_prev_rd = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_addr    = '0;
        state_nxt      = S_INIT2;
      end
      S_INIT2: begin
        cmd.ld_cur_rd = 1'b1;
        cur_nxt       = '0;
        havek_nxt     = 1'b0;
        keep_nxt      = '0;
        state_nxt     = S_FETCH;
      end
      // Successor: next stored vertex, or wrap to the first kept one (the current vertex itself if none is kept yet).
      S_FETCH: begin
        if (cur_r == nlast_r) begin
          cmd.nx_sel = havek_r ? NX_FIRST : NX_CUR;
          state_nxt  = S_TEST;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = cur_r + IDX_W'(1);
          state_nxt   = S_FLAT;
        end
      end
      S_FLAT: begin
        cmd.nx_sel = NX_MEM;
        state_nxt  = S_TEST;
      end
      S_TEST: begin
        if (status.point_close) begin
          rm_nxt    = 1'b1;
          state_nxt = S_APPLY;
        end else begin
          step_nxt  = ST_D1A;
          state_nxt = S_MISSUE;
        end
      end
      S_MISSUE: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MWAIT;
      end
      S_MWAIT: begin
        if (status.mul_done) state_nxt = S_NEXT;
      end
      // Pick the next multiply step or settle the decision.
      S_NEXT: begin
        state_nxt = S_MISSUE;
        case (step_r)
          ST_D1A:  step_nxt = ST_D1B;
          ST_D1B:  step_nxt = status.acc_neg ? ST_EAP1 : ST_D2A;
          ST_EAP1: step_nxt = ST_EAP2;
          ST_EAP2: step_nxt = ST_LL;
          ST_D2A:  step_nxt = ST_D2B;
          ST_D2B: begin
            if (status.acc_pos) begin
              step_nxt = ST_ED1;
            end else if (status.ab_zero) begin
              rm_nxt    = 1'b0;
              state_nxt = S_APPLY;
            end else begin
              step_nxt = ST_C1;
            end
          end
          ST_ED1:  step_nxt = ST_ED2;
          ST_ED2:  step_nxt = ST_LL;
          ST_LL: begin
            rm_nxt    = status.sum_lt_aux;
            state_nxt = S_APPLY;
          end
          ST_C1:   step_nxt = ST_C2;
          ST_C2:   step_nxt = ST_CSQ;
          ST_CSQ:  step_nxt = ST_AB1;
          ST_AB1:  step_nxt = ST_AB2;
          ST_AB2:  step_nxt = ST_CL;
          ST_CL:   step_nxt = ST_CR;
          ST_CR: begin
            rm_nxt    = status.sq_lt_aux;
            state_nxt = S_APPLY;
          end
          default: state_nxt = S_APPLY;
        endcase
      end
      // Record the decision and step to the next stored vertex, or after the last one start the output scan.
      S_APPLY: begin
        keep_nxt[cur_r] = !rm_r;
        cmd.adv         = 1'b1;
        cmd.keep        = !rm_r;
        cmd.set_first   = !rm_r && !havek_r;
        if (!rm_r) begin
          havek_nxt = 1'b1;
          lastk_nxt = cur_r;
        end
        if (cur_r == nlast_r) begin
          e_nxt     = '0;
          state_nxt = S_ESCAN;
        end else begin
          cur_nxt   = cur_r + IDX_W'(1);
          state_nxt = S_FETCH;
        end
      end
      // Walk the store and pick out the kept vertices; with none kept, emit one empty result.
      S_ESCAN: begin
        if (!havek_r) begin
          cmd.out_ld    = 1'b1;
          cmd.out_empty = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.out_ovf   = ovf_r;
          state_nxt     = S_EOUT;
        end else if (keep_r[e_r]) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = e_r;
          state_nxt   = S_ELAT;
        end else begin
          e_nxt = e_r + IDX_W'(1);
        end
      end
      S_ELAT: begin
        cmd.out_ld   = 1'b1;
        cmd.out_last = (e_r == lastk_r);
        cmd.out_ovf  = ovf_r;
        state_nxt    = S_EOUT;
      end
      S_EOUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (!havek_r || (e_r == lastk_r)) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + IDX_W'(1);
            state_nxt = S_ESCAN;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end
endmodule

>>> rtl/core/polygon_vertex_simplifier.sv
// Top level of the polygon vertex simplifier: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_vertex_x, in_vertex_y, in_last_vertex
//   out      output     out_valid / out_stall out_x, out_y, out_last_out,
//                                             out_empty_result, out_overflowed
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// Loading accepts one vertex per cycle. After the last vertex, each scanned vertex
// needs, unless the point test removes it, 4 to 11 products on the bit-serial
// multiplier, one product at a time. Emission walks the stored vertices and
// holds while out_stall is high. Reset is synchronous and needs no clearing
// pass; inputs stall from the last vertex until the final result transfer.
module polygon_vertex_simplifier (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pvs_pkg::COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [pvs_pkg::COORD_WIDTH-1:0] in_vertex_y,
  input  logic                                   in_last_vertex,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [pvs_pkg::COORD_WIDTH-1:0] out_x,
  output logic signed [pvs_pkg::COORD_WIDTH-1:0] out_y,
  output logic                                   out_last_out,
  output logic                                   out_empty_result,
  output logic                                   out_overflowed,
  input  logic                                   cfg_we,
  input  logic [pvs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pvs_pkg::THR_WIDTH-1:0]          cfg_wdata
);
  import pvs_pkg::*;

  cmd_t    cmd;
  status_t status;

  pvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last_vertex),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pvs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_x      (in_vertex_x),
    .in_y      (in_vertex_y),
    .cmd       (cmd),
    .status    (status),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_last  (out_last_out),
    .out_empty (out_empty_result),
    .out_ovf   (out_overflowed)
  );
endmodule

>>> rtl/core/pvs_checker.sv
// Port-level assertions for the polygon vertex simplifier and their bind.
module pvs_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   in_last_vertex,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [pvs_pkg::COORD_WIDTH-1:0] out_x,
  input logic signed [pvs_pkg::COORD_WIDTH-1:0] out_y,
  input logic                                   out_last_out,
  input logic                                   out_empty_result,
  input logic                                   out_overflowed
);
  // No new vertex is taken while a result is on offer.
  a_no_load_during_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open while emitting");

  // An empty result is always the only, and final, transfer of a polygon.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_result |-> out_last_out) else $error("empty not last");

  // The final vertex closes the input until the polygon is emitted.
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_vertex |=> in_stall && !out_valid)
    else $error("input not closed after final vertex");

  // The final result transfer reopens the input.
  a_last_reopens_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_out |=> !in_stall)
    else $error("input not reopened");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y) &&
      $stable(out_last_out) && $stable(out_empty_result) && $stable(out_overflowed))
    else $error("stalled result changed");
endmodule

bind polygon_vertex_simplifier pvs_checker u_pvs_checker (.*);
